>>> src/scaler_delta_per_second_binner_top_assert.svh
// Assertion macros used by the checker of the per-second scaler binner.
`ifndef SCALER_DELTA_PER_SECOND_BINNER_TOP_ASSERT_SVH
`define SCALER_DELTA_PER_SECOND_BINNER_TOP_ASSERT_SVH

// Overlapping implication, checked on clk and disabled while rst_n is low.
`define SDB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SDB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/sdb_pkg.sv
// Types, constants and helper functions of the per-second scaler binner.
package sdb_pkg;

    localparam int SCALER_WIDTH = 32;
    localparam int FIELD_WIDTH  = 32;
    localparam int CHANNELS     = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef logic [SCALER_WIDTH-1:0] scaler_t;
    typedef logic [FIELD_WIDTH-1:0]  field_t;
    typedef logic [PTR_W-1:0]        ptr_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_RELOAD,
        CMD_ACCUM,
        CMD_EMIT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                           kind;
        field_t                              elapsed;
        logic [CHANNELS-1:0][SCALER_WIDTH-1:0] scaler;
    } cmd_t;

    typedef struct packed {
        logic [CHANNELS-1:0][FIELD_WIDTH-1:0] sum;
        field_t                               elapsed;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic scaler_t to_scaler(input field_t x);
        logic [63:0] w;
        w = {32'd0, x};
        return w[SCALER_WIDTH-1:0];
    endfunction

    function automatic field_t to_field(input scaler_t s);
        logic [63:0] w;
        w = 64'(s);
        return w[FIELD_WIDTH-1:0];
    endfunction

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

>>> src/sdb_front.sv
// Front part: tracks the clock second and classifies each snapshot.
module sdb_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  sdb_pkg::field_t        clock_second,
    input  sdb_pkg::field_t [7:0]  counts,
    output logic                   cmd_push,
    output sdb_pkg::cmd_t          cmd
);
    import sdb_pkg::*;

    logic   awaiting_first_reg, awaiting_first_next;
    field_t current_second_reg, current_second_next;
    field_t base_second_reg, base_second_next;

    always_comb
    begin
        awaiting_first_next = awaiting_first_reg;
        current_second_next = current_second_reg;
        base_second_next    = base_second_reg;
        cmd.elapsed         = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            cmd.scaler[c] = to_scaler(counts[c]);
        end
        if (awaiting_first_reg)
        begin
            cmd.kind            = CMD_LOAD;
            current_second_next = clock_second;
            base_second_next    = clock_second;
        end
        else if (clock_second < current_second_reg)
        begin
            // A backward step moves the base up by the new clock second plus one.
            cmd.kind            = CMD_RELOAD;
            current_second_next = clock_second;
            base_second_next    = base_second_reg + clock_second + FIELD_WIDTH'(1);
        end
        else if (clock_second == current_second_reg)
        begin
            cmd.kind = CMD_ACCUM;
        end
        else
        begin
            cmd.kind            = CMD_EMIT;
            cmd.elapsed         = current_second_reg - base_second_reg;
            current_second_next = clock_second;
        end
        if (accept)
        begin
            awaiting_first_next = 1'b0;
        end
        else
        begin
            current_second_next = current_second_reg;
            base_second_next    = base_second_reg;
        end
    end

    assign cmd_push = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_first_reg <= 1'b1;
            current_second_reg <= '0;
            base_second_reg    <= '0;
        end
        else
        begin
            awaiting_first_reg <= awaiting_first_next;
            current_second_reg <= current_second_next;
            base_second_reg    <= base_second_next;
        end
    end

endmodule

>>> src/sdb_cmd_queue.sv
// Short queue of classified commands between the front and back parts.
module sdb_cmd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sdb_pkg::cmd_t        push_data,
    input  logic                 pop,
    output sdb_pkg::cmd_t        pop_data,
    output sdb_pkg::q_status_t   status
);
    import sdb_pkg::*;

    cmd_t mem_reg [QUEUE_DEPTH];
    ptr_t wr_ptr_reg, wr_ptr_next;
    ptr_t rd_ptr_reg, rd_ptr_next;
    cnt_t count_reg, count_next;
    logic do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/sdb_back.sv
// Back part: eight subtract-accumulate lanes that build the per-second sums.
module sdb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdb_pkg::q_status_t   cmd_status,
    input  sdb_pkg::cmd_t        cmd,
    output logic                 cmd_pop,
    input  sdb_pkg::q_status_t   res_status,
    output logic                 res_push,
    output sdb_pkg::result_t     result
);
    import sdb_pkg::*;

    scaler_t prev_reg [CHANNELS];
    scaler_t prev_next [CHANNELS];
    scaler_t sum_reg [CHANNELS];
    scaler_t sum_next [CHANNELS];
    scaler_t diff [CHANNELS];
    logic    fire;

    // Only a second boundary needs room in the result queue.
    assign fire     = !cmd_status.empty && ((cmd.kind != CMD_EMIT) || !res_status.full);
    assign cmd_pop  = fire;
    assign res_push = fire && (cmd.kind == CMD_EMIT);

    always_comb
    begin
        result.elapsed = cmd.elapsed;
        for (int c = 0; c < CHANNELS; c++)
        begin
            diff[c]       = cmd.scaler[c] - prev_reg[c];
            result.sum[c] = to_field(sum_reg[c]);
            prev_next[c]  = prev_reg[c];
            sum_next[c]   = sum_reg[c];
            if (fire)
            begin
                prev_next[c] = cmd.scaler[c];
                case (cmd.kind)
                    CMD_LOAD:   sum_next[c] = '0;
                    CMD_RELOAD: sum_next[c] = sum_reg[c];
                    CMD_ACCUM:  sum_next[c] = sum_reg[c] + diff[c];
                    CMD_EMIT:   sum_next[c] = diff[c];
                    default:    sum_next[c] = sum_reg[c];
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                prev_reg[c] <= '0;
                sum_reg[c]  <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                prev_reg[c] <= prev_next[c];
                sum_reg[c]  <= sum_next[c];
            end
        end
    end

endmodule

>>> src/sdb_result_queue.sv
// Output queue that holds finished per-second results until they are taken.
module sdb_result_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sdb_pkg::result_t     push_data,
    input  logic                 pop,
    output sdb_pkg::result_t     pop_data,
    output sdb_pkg::q_status_t   status
);
    import sdb_pkg::*;

    result_t mem_reg [QUEUE_DEPTH];
    ptr_t    wr_ptr_reg, wr_ptr_next;
    ptr_t    rd_ptr_reg, rd_ptr_next;
    cnt_t    count_reg, count_next;
    logic    do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/scaler_delta_per_second_binner_top.sv
// Top level of the per-second scaler binner.
//
// Input channel: a queue write port. A snapshot (clock_second and eight scaler
// counts) transfers at a rising edge with push high and full low.
// Result channel: a queue read port. While empty is low the oldest result is on
// the sum and elapsed_seconds ports; it transfers at an edge with pop high.
// Throughput is one snapshot per cycle while full is low: the back part's eight
// subtract-accumulate lanes take one command every cycle while not stalled.
// A snapshot's command passes through the command queue; the back part then
// writes the result into the result queue, from whose head it transfers.
// A snapshot yields a result only when its second is later than the current
// one; the first snapshot after reset and backward clock steps yield none.
// Reset clears both queues, the clock tracking and all lane registers; full
// and empty read low and high right after it.
// When the receiver stalls, results collect in a two-entry output queue, then
// commands collect in a two-entry command queue, and then full rises. While the
// output queue is full, snapshots without a result still drain until one that
// ends a second reaches the head of the command queue.
module scaler_delta_per_second_binner_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  sdb_pkg::field_t     clock_second,
    input  sdb_pkg::field_t     accepted_trigger_count,
    input  sdb_pkg::field_t     free_trigger_count,
    input  sdb_pkg::field_t     monitor_new_count,
    input  sdb_pkg::field_t     monitor_old_count,
    input  sdb_pkg::field_t     ion_chamber_count,
    input  sdb_pkg::field_t     scint_a_count,
    input  sdb_pkg::field_t     scint_b_count,
    input  sdb_pkg::field_t     scint_c_count,
    output logic                empty,
    input  logic                pop,
    output sdb_pkg::field_t     accepted_trigger_sum,
    output sdb_pkg::field_t     free_trigger_sum,
    output sdb_pkg::field_t     monitor_new_sum,
    output sdb_pkg::field_t     monitor_old_sum,
    output sdb_pkg::field_t     ion_chamber_sum,
    output sdb_pkg::field_t     scint_a_sum,
    output sdb_pkg::field_t     scint_b_sum,
    output sdb_pkg::field_t     scint_c_sum,
    output sdb_pkg::field_t     elapsed_seconds
);
    import sdb_pkg::*;

    field_t [7:0] counts;
    logic         accept;
    logic         cmd_push;
    cmd_t         cmd_in;
    cmd_t         cmd_out;
    logic         cmd_pop;
    q_status_t    cmd_status;
    logic         res_push;
    result_t      res_in;
    result_t      res_out;
    q_status_t    res_status;

    assign counts[0] = accepted_trigger_count;
    assign counts[1] = free_trigger_count;
    assign counts[2] = monitor_new_count;
    assign counts[3] = monitor_old_count;
    assign counts[4] = ion_chamber_count;
    assign counts[5] = scint_a_count;
    assign counts[6] = scint_b_count;
    assign counts[7] = scint_c_count;

    assign full   = cmd_status.full;
    assign accept = push && !cmd_status.full;

    sdb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .clock_second (clock_second),
        .counts       (counts),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    sdb_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .status    (cmd_status)
    );

    sdb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_status (cmd_status),
        .cmd        (cmd_out),
        .cmd_pop    (cmd_pop),
        .res_status (res_status),
        .res_push   (res_push),
        .result     (res_in)
    );

    sdb_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .pop       (pop),
        .pop_data  (res_out),
        .status    (res_status)
    );

    assign empty                = res_status.empty;
    assign accepted_trigger_sum = res_out.sum[0];
    assign free_trigger_sum     = res_out.sum[1];
    assign monitor_new_sum      = res_out.sum[2];
    assign monitor_old_sum      = res_out.sum[3];
    assign ion_chamber_sum      = res_out.sum[4];
    assign scint_a_sum          = res_out.sum[5];
    assign scint_b_sum          = res_out.sum[6];
    assign scint_c_sum          = res_out.sum[7];
    assign elapsed_seconds      = res_out.elapsed;

endmodule

>>> src/sdb_checker.sv
// Port-level checker of the per-second scaler binner and its bind statement.
`include "scaler_delta_per_second_binner_top_assert.svh"

module sdb_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  logic             empty,
    input  logic             pop,
    input  sdb_pkg::field_t  accepted_trigger_sum,
    input  sdb_pkg::field_t  elapsed_seconds
);
    import sdb_pkg::*;

    // Number of input transfers since reset, saturating at two.
    logic [1:0] seen_reg, seen_next;

    always_comb
    begin
        seen_next = seen_reg;
        if (push && !full && (seen_reg != 2'd2))
        begin
            seen_next = seen_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    // A result needs at least two snapshots: the first one only loads values.
    `SDB_ASSERT_SAME(a_result_after_two, !empty, seen_reg == 2'd2)

    // Coming out of reset both queues are empty.
    `SDB_ASSERT_SAME(a_reset_state, $rose(rst_n), empty && !full)

    // The queue cannot fill before anything was written into it.
    `SDB_ASSERT_SAME(a_full_needs_input, full, seen_reg != 2'd0)

    // A waiting result that is not taken keeps its value.
    `SDB_ASSERT_NEXT(a_result_holds, !empty && !pop,
        !empty && $stable(elapsed_seconds) && $stable(accepted_trigger_sum))

endmodule

bind scaler_delta_per_second_binner_top sdb_checker u_sdb_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .empty                (empty),
    .pop                  (pop),
    .accepted_trigger_sum (accepted_trigger_sum),
    .elapsed_seconds      (elapsed_seconds)
);
